/* hdl/aes128_key_expansion_macros.svh */
// Assertion macros shared by the AES-128 key expansion checker.
`ifndef AES128_KEY_EXPANSION_MACROS_SVH
`define AES128_KEY_EXPANSION_MACROS_SVH

// Same-cycle implication, sampled on i_clk and off while reset is held.
`define KE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk and off while reset is held.
`define KE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/aes128ke_pkg.sv */
// Shared types, tables and helper functions for the AES-128 key expansion.
`timescale 1ns / 1ps

package aes128ke_pkg;

    // Number of rounds of AES-128.
    localparam int KE_ROUNDS = 10;

    // Four 32-bit words of one round key; index 0 is the first word.
    typedef logic [3:0][31:0] t_words;

    // AES forward S-box.
    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7C, 8'h77, 8'h7B, 8'hF2, 8'h6B, 8'h6F, 8'hC5,
        8'h30, 8'h01, 8'h67, 8'h2B, 8'hFE, 8'hD7, 8'hAB, 8'h76,
        8'hCA, 8'h82, 8'hC9, 8'h7D, 8'hFA, 8'h59, 8'h47, 8'hF0,
        8'hAD, 8'hD4, 8'hA2, 8'hAF, 8'h9C, 8'hA4, 8'h72, 8'hC0,
        8'hB7, 8'hFD, 8'h93, 8'h26, 8'h36, 8'h3F, 8'hF7, 8'hCC,
        8'h34, 8'hA5, 8'hE5, 8'hF1, 8'h71, 8'hD8, 8'h31, 8'h15,
        8'h04, 8'hC7, 8'h23, 8'hC3, 8'h18, 8'h96, 8'h05, 8'h9A,
        8'h07, 8'h12, 8'h80, 8'hE2, 8'hEB, 8'h27, 8'hB2, 8'h75,
        8'h09, 8'h83, 8'h2C, 8'h1A, 8'h1B, 8'h6E, 8'h5A, 8'hA0,
        8'h52, 8'h3B, 8'hD6, 8'hB3, 8'h29, 8'hE3, 8'h2F, 8'h84,
        8'h53, 8'hD1, 8'h00, 8'hED, 8'h20, 8'hFC, 8'hB1, 8'h5B,
        8'h6A, 8'hCB, 8'hBE, 8'h39, 8'h4A, 8'h4C, 8'h58, 8'hCF,
        8'hD0, 8'hEF, 8'hAA, 8'hFB, 8'h43, 8'h4D, 8'h33, 8'h85,
        8'h45, 8'hF9, 8'h02, 8'h7F, 8'h50, 8'h3C, 8'h9F, 8'hA8,
        8'h51, 8'hA3, 8'h40, 8'h8F, 8'h92, 8'h9D, 8'h38, 8'hF5,
        8'hBC, 8'hB6, 8'hDA, 8'h21, 8'h10, 8'hFF, 8'hF3, 8'hD2,
        8'hCD, 8'h0C, 8'h13, 8'hEC, 8'h5F, 8'h97, 8'h44, 8'h17,
        8'hC4, 8'hA7, 8'h7E, 8'h3D, 8'h64, 8'h5D, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4F, 8'hDC, 8'h22, 8'h2A, 8'h90, 8'h88,
        8'h46, 8'hEE, 8'hB8, 8'h14, 8'hDE, 8'h5E, 8'h0B, 8'hDB,
        8'hE0, 8'h32, 8'h3A, 8'h0A, 8'h49, 8'h06, 8'h24, 8'h5C,
        8'hC2, 8'hD3, 8'hAC, 8'h62, 8'h91, 8'h95, 8'hE4, 8'h79,
        8'hE7, 8'hC8, 8'h37, 8'h6D, 8'h8D, 8'hD5, 8'h4E, 8'hA9,
        8'h6C, 8'h56, 8'hF4, 8'hEA, 8'h65, 8'h7A, 8'hAE, 8'h08,
        8'hBA, 8'h78, 8'h25, 8'h2E, 8'h1C, 8'hA6, 8'hB4, 8'hC6,
        8'hE8, 8'hDD, 8'h74, 8'h1F, 8'h4B, 8'hBD, 8'h8B, 8'h8A,
        8'h70, 8'h3E, 8'hB5, 8'h66, 8'h48, 8'h03, 8'hF6, 8'h0E,
        8'h61, 8'h35, 8'h57, 8'hB9, 8'h86, 8'hC1, 8'h1D, 8'h9E,
        8'hE1, 8'hF8, 8'h98, 8'h11, 8'h69, 8'hD9, 8'h8E, 8'h94,
        8'h9B, 8'h1E, 8'h87, 8'hE9, 8'hCE, 8'h55, 8'h28, 8'hDF,
        8'h8C, 8'hA1, 8'h89, 8'h0D, 8'hBF, 8'hE6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2D, 8'h0F, 8'hB0, 8'h54, 8'hBB, 8'h16
    };

    // Round constants for rounds 1 through 10.
    localparam logic [7:0] RCON [10] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1B, 8'h36
    };

    // Round constant of a round; rounds outside 1..10 use zero.
    function automatic logic [7:0] rcon_of(input logic [3:0] round);
        logic [7:0] rc;
        rc = 8'h00;
        if (round >= 4'd1 && round <= 4'd10) begin
            rc = RCON[4'(round - 4'd1)];
        end
        return rc;
    endfunction

endpackage

/* hdl/aes128ke_round.sv */
// Shared round unit: derives the next AES-128 round key from the current one.
`timescale 1ns / 1ps

module aes128ke_round import aes128ke_pkg::*; (
    input  t_words     i_words,   // current round key, word 0 first
    input  logic [3:0] i_round,   // number of the round being produced
    output t_words     o_words    // round key of i_round
);

    logic [31:0] sub_rot;
    logic [31:0] temp;

    // RotWord then SubWord on the last word, with the round constant on top.
    always_comb begin
        sub_rot = {SBOX[i_words[3][23:16]], SBOX[i_words[3][15:8]],
                   SBOX[i_words[3][7:0]],   SBOX[i_words[3][31:24]]};
        temp    = sub_rot ^ {rcon_of(i_round), 24'h000000};
    end

    // Each new word folds in the word just produced.
    always_comb begin
        o_words[0] = i_words[0] ^ temp;
        o_words[1] = i_words[1] ^ o_words[0];
        o_words[2] = i_words[2] ^ o_words[1];
        o_words[3] = i_words[3] ^ o_words[2];
    end

endmodule

/* hdl/aes128_key_expansion.sv */
// AES-128 key expansion: master key in, eleven round keys out.
//
// Usage:
//   The slave channel takes one 128-bit master key per transfer
//   (s_axis_tdata: key_high in bits 63:0, key_low in bits 127:64, key byte 0
//   in bits 63:56). The master channel returns the eleven round keys in order,
//   rounds 0 to 10, one per transfer; tuser carries the round number and
//   tlast marks the round 10 key.
//   Round 0 appears in the cycle after the key transfer. One shared round unit
//   produces one round key per cycle while the output is not stalled, so with
//   the receiver always ready the eleven keys leave on consecutive cycles and
//   a new key is taken in the cycle the round 10 key leaves.
//   s_axis_tready is high only while no expansion is running and the output
//   register is free or being emptied.
//   When the receiver stalls, the output register holds its round key and the
//   round unit waits; nothing is lost.
//   Reset (i_rst_n low, synchronous) empties the output register and returns
//   the sequencer to idle.
`timescale 1ns / 1ps

module aes128_key_expansion import aes128ke_pkg::*; #(
    parameter int ROUNDS = KE_ROUNDS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // key_high [63:0], key_low [127:64]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,  // round_key_high [63:0], round_key_low [127:64]
    output logic [3:0]   m_axis_tuser,  // round_index [3:0]
    output logic         m_axis_tlast
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic       r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic [3:0] r_round, n_round;
    t_words     r_words;
    t_words     r_out_words;
    logic [3:0] r_out_round;

    logic       out_free;
    logic       in_take;
    logic       advance;
    t_words     key_words;
    t_words     rnd_src;
    logic [3:0] rnd_num;
    t_words     rnd_next;

    // Handshake qualifiers.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && out_free;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign advance       = (r_state == ST_RUN) && out_free;

    // Master key as big-endian words.
    assign key_words[0] = s_axis_tdata[63:32];
    assign key_words[1] = s_axis_tdata[31:0];
    assign key_words[2] = s_axis_tdata[127:96];
    assign key_words[3] = s_axis_tdata[95:64];

    // The round unit starts from the key when idle, else from the held words.
    always_comb begin
        if (r_state == ST_IDLE) begin
            rnd_src = key_words;
            rnd_num = 4'd1;
        end else begin
            rnd_src = r_words;
            rnd_num = 4'(r_round + 4'd1);
        end
    end

    aes128ke_round u_round (
        .i_words (rnd_src),
        .i_round (rnd_num),
        .o_words (rnd_next)
    );

    // Sequencer next state.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_round     = r_round;
        unique case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    n_state     = ST_RUN;
                    n_out_valid = 1'b1;
                    n_round     = 4'd1;
                end else if (m_axis_tready) begin
                    n_out_valid = 1'b0;
                end
            end
            ST_RUN: begin
                if (advance) begin
                    n_out_valid = 1'b1;
                    n_round     = 4'(r_round + 4'd1);
                    if (r_round == 4'(ROUNDS)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_round     <= 4'd0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_round     <= n_round;
        end
    end

    // Working words and the output register.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_out_words <= key_words;
            r_out_round <= 4'd0;
            r_words     <= rnd_next;
        end else if (advance) begin
            r_out_words <= r_words;
            r_out_round <= r_round;
            r_words     <= rnd_next;
        end
    end

    // Output channel.
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_words[2], r_out_words[3], r_out_words[0], r_out_words[1]};
    assign m_axis_tuser  = r_out_round;
    assign m_axis_tlast  = (r_out_round == 4'(ROUNDS));

endmodule

/* hdl/aes128ke_checker.sv */
// Port-level checks for the AES-128 key expansion, bound to the top level.
`timescale 1ns / 1ps
`include "aes128_key_expansion_macros.svh"

module aes128ke_checker import aes128ke_pkg::*; #(
    parameter int ROUNDS = KE_ROUNDS
) (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata,   // round_key_high [63:0], round_key_low [127:64]
    input logic [3:0]   m_axis_tuser,   // round_index [3:0]
    input logic         m_axis_tlast
);

    // A stalled round key holds.
    `KE_ASSERT_NEXT(a_stall_hold,
        m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
        "round key changed while stalled")

    // A key transfer puts round 0 on the output next cycle.
    `KE_ASSERT_NEXT(a_round0_follows,
        s_axis_tvalid && s_axis_tready,
        m_axis_tvalid && (m_axis_tuser == 4'd0),
        "round 0 did not follow the key")

    // Each round key but the last is followed at once by the next round.
    `KE_ASSERT_NEXT(a_round_step,
        m_axis_tvalid && m_axis_tready && (m_axis_tuser != 4'(ROUNDS)),
        m_axis_tvalid && (m_axis_tuser == 4'($past(m_axis_tuser) + 4'd1)),
        "round sequence broken")

    // No new key is taken while a run is still on the output.
    `KE_ASSERT_NOW(a_busy_no_key,
        m_axis_tvalid && (m_axis_tuser != 4'(ROUNDS)),
        !s_axis_tready,
        "key taken during a run")

    // tlast marks exactly the final round.
    `KE_ASSERT_NOW(a_last_mark,
        m_axis_tvalid,
        m_axis_tlast == (m_axis_tuser == 4'(ROUNDS)),
        "tlast does not match the final round")

endmodule

bind aes128_key_expansion aes128ke_checker #(.ROUNDS(ROUNDS)) u_checker (.*);
